@@ design/rtpl_pkg.sv @@
// shared types and constants for the rtp l16 depacketizer
package rtpl_pkg;

  localparam int unsigned MAX_PACKET_BYTES = 65536;
  localparam int unsigned POS_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam int unsigned CALC_W = 20;

  localparam logic [6:0]  PT_STEREO = 7'd10;
  localparam logic [6:0]  PT_MONO   = 7'd11;
  localparam logic [17:0] RATE_44K  = 18'd44100;
  localparam logic [17:0] RATE_MIN  = 18'd1000;
  localparam logic [29:0] NS_PER_S  = 30'd1000000000;

  localparam int unsigned PROD_W = 62;

  localparam logic [1:0] CFG_DYN_TYPE     = 2'd0;
  localparam logic [1:0] CFG_DYN_RATE     = 2'd1;
  localparam logic [1:0] CFG_DYN_CHANNELS = 2'd2;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

  // one classified byte with everything the back end needs
  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        end_of_packet;
    logic [1:0]  rtp_version;
    logic        marker_bit;
    logic [6:0]  packet_type;
    logic [15:0] sequence_res;
    logic [31:0] source_id;
    logic [7:0]  trim_count;
    logic [31:0] ts_delta;
    logic [17:0] rate;
    logic [1:0]  channel_count;
    logic        unknown_type;
  } item_t;

endpackage

@@ design/rtpl_front.sv @@
// front end: config registers, header parse and payload classification
module rtpl_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [17:0]         cfg_data_i,
  input  logic                in_take_i,
  input  logic [7:0]          data_byte_i,
  input  logic                first_byte_i,
  input  logic                last_byte_i,
  output rtpl_pkg::item_t     item_o
);

  logic [6:0]  dyn_type_q;
  logic [17:0] dyn_rate_q;
  logic [1:0]  dyn_ch_q;

  logic [rtpl_pkg::POS_W-1:0] pos_q, pos_d, p;
  logic [3:0]  flags_q, flags_d;
  logic [3:0]  sc_q, sc_d;
  logic [15:0] ew_q, ew_d;
  logic [15:0] seq_q, seq_d;
  logic [31:0] ts_q, ts_d;
  logic [31:0] ssrc_q, ssrc_d;
  logic [7:0]  tm_q, tm_d;
  logic [6:0]  cur_q, cur_d;
  logic [17:0] rate_q, rate_d;
  logic [1:0]  ch_q, ch_d;
  logic        started_q, started_d;
  logic [31:0] first_ts_q, first_ts_d;

  logic [rtpl_pkg::CALC_W-1:0] pe, hdr_end, start;
  logic        ext, payload;
  logic [6:0]  pt;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dyn_type_q <= 7'd96;
      dyn_rate_q <= rtpl_pkg::RATE_44K;
      dyn_ch_q   <= 2'd2;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rtpl_pkg::CFG_DYN_TYPE:     dyn_type_q <= cfg_data_i[6:0];
        rtpl_pkg::CFG_DYN_RATE:     dyn_rate_q <= cfg_data_i;
        rtpl_pkg::CFG_DYN_CHANNELS: dyn_ch_q   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // header parse and classification
  always_comb begin
    p = first_byte_i ? '0 : pos_q;
    pe = rtpl_pkg::CALC_W'(p);
    flags_d = flags_q; sc_d = sc_q; ew_d = ew_q; seq_d = seq_q;
    ts_d = ts_q; ssrc_d = ssrc_q; tm_d = tm_q;
    cur_d = cur_q; rate_d = rate_q; ch_d = ch_q;
    started_d = started_q; first_ts_d = first_ts_q;

    if (pe == 20'd0) begin
      flags_d = data_byte_i[7:4];
      sc_d    = data_byte_i[3:0];
      ew_d = '0; seq_d = '0; ts_d = '0; ssrc_d = '0; tm_d = '0;
    end else if (pe == 20'd1) begin
      tm_d = data_byte_i;
    end else if (pe < 20'd4) begin
      seq_d = {seq_q[7:0], data_byte_i};
    end else if (pe < 20'd8) begin
      ts_d = {ts_q[23:0], data_byte_i};
    end else if (pe < 20'd12) begin
      ssrc_d = {ssrc_q[23:0], data_byte_i};
    end

    ext = flags_d[0];
    hdr_end = 20'd12 + rtpl_pkg::CALC_W'({sc_d, 2'b00});
    if (ext && pe == hdr_end + 20'd2) begin
      ew_d = {data_byte_i, 8'h00};
    end else if (ext && pe == hdr_end + 20'd3) begin
      ew_d = {ew_q[15:8], data_byte_i};
    end
    start = hdr_end + (ext ? (20'd4 + rtpl_pkg::CALC_W'({ew_d, 2'b00})) : 20'd0);
    payload = (pe >= start) &&
              (pe < rtpl_pkg::CALC_W'(rtpl_pkg::MAX_PACKET_BYTES));

    pt = tm_d[6:0];
    // rate and channels follow a change to a known payload type
    if (last_byte_i && pt != cur_q) begin
      cur_d = pt;
      if (pt == rtpl_pkg::PT_MONO) begin
        ch_d = 2'd1; rate_d = rtpl_pkg::RATE_44K;
      end else if (pt == rtpl_pkg::PT_STEREO) begin
        ch_d = 2'd2; rate_d = rtpl_pkg::RATE_44K;
      end else if (pt == dyn_type_q) begin
        rate_d = (dyn_rate_q < rtpl_pkg::RATE_MIN) ? rtpl_pkg::RATE_MIN : dyn_rate_q;
        ch_d = (dyn_ch_q == 2'd0) ? 2'd1 : ((dyn_ch_q == 2'd3) ? 2'd2 : dyn_ch_q);
      end
    end
    if (last_byte_i && !started_q) begin
      started_d  = 1'b1;
      first_ts_d = ts_d;
    end

    if (last_byte_i) begin
      pos_d = '0;
    end else if (p == rtpl_pkg::POS_W'(rtpl_pkg::MAX_PACKET_BYTES)) begin
      pos_d = p;
    end else begin
      pos_d = p + 1'b1;
    end

    item_o = '0;
    item_o.payload_valid = payload;
    item_o.payload_byte  = payload ? data_byte_i : 8'h00;
    item_o.channel_count = ch_d;
    if (last_byte_i) begin
      item_o.end_of_packet = 1'b1;
      item_o.rtp_version   = flags_d[3:2];
      item_o.marker_bit    = tm_d[7];
      item_o.packet_type   = pt;
      item_o.sequence_res  = seq_d;
      item_o.source_id     = ssrc_d;
      item_o.trim_count    = flags_d[1] ? data_byte_i : 8'h00;
      item_o.ts_delta      = ts_d - first_ts_d;
      item_o.rate          = rate_d;
      item_o.unknown_type  = (pt != rtpl_pkg::PT_STEREO) && (pt != rtpl_pkg::PT_MONO) &&
                             (pt != dyn_type_q);
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; flags_q <= '0; sc_q <= '0; ew_q <= '0; seq_q <= '0;
      ts_q <= '0; ssrc_q <= '0; tm_q <= '0;
      cur_q <= rtpl_pkg::PT_STEREO; rate_q <= rtpl_pkg::RATE_44K; ch_q <= 2'd2;
      started_q <= 1'b0; first_ts_q <= '0;
    end else if (in_take_i) begin
      pos_q <= pos_d; flags_q <= flags_d; sc_q <= sc_d; ew_q <= ew_d; seq_q <= seq_d;
      ts_q <= ts_d; ssrc_q <= ssrc_d; tm_q <= tm_d;
      cur_q <= cur_d; rate_q <= rate_d; ch_q <= ch_d;
      started_q <= started_d; first_ts_q <= first_ts_d;
    end
  end

endmodule

@@ design/rtpl_queue.sv @@
// short register queue between front and back end
module rtpl_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rtpl_pkg::item_t push_item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            avail_o,
  output rtpl_pkg::item_t head_o
);

  rtpl_pkg::item_t mem_q [rtpl_pkg::QUEUE_DEPTH];
  logic [rtpl_pkg::QPTR_W-1:0] wr_q, rd_q;
  logic [rtpl_pkg::QPTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (rtpl_pkg::QPTR_W+1)'(rtpl_pkg::QUEUE_DEPTH));
  assign avail_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (rtpl_pkg::QPTR_W+1)'(push_i) - (rtpl_pkg::QPTR_W+1)'(pop_i);
    end
  end

endmodule

@@ design/rtpl_back.sv @@
// back end: presentation time divider and output register
module rtpl_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            avail_i,
  input  rtpl_pkg::item_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output rtpl_pkg::item_t out_item_o,
  output logic [51:0]     time_ns_o
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;

  logic [1:0]  ph_q, ph_d;
  logic        ov_q, ov_d;
  logic        can_load;
  logic [5:0]  cnt_q;
  logic [31:0] delta_q;
  logic [17:0] rate_q;
  logic [rtpl_pkg::PROD_W-1:0] dq_q;
  logic [17:0] rem_q;
  logic [18:0] trial;
  logic        qbit;
  rtpl_pkg::item_t item_q;
  logic [51:0] tns_q;

  assign can_load = !ov_q || !out_stall_i;
  assign pop_o    = (ph_q == PH_IDLE) && avail_i && can_load;
  assign out_valid_o = ov_q;
  assign out_item_o  = item_q;
  assign time_ns_o   = tns_q;

  // one restoring division step
  assign trial = {rem_q, dq_q[rtpl_pkg::PROD_W-1]};
  assign qbit  = (trial >= {1'b0, rate_q});

  // control
  always_comb begin
    ph_d = ph_q;
    ov_d = ov_q;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    case (ph_q)
      PH_IDLE: begin
        if (pop_o) begin
          ov_d = !head_i.end_of_packet;
          if (head_i.end_of_packet) ph_d = PH_MUL;
        end
      end
      PH_MUL: ph_d = PH_DIV;
      PH_DIV: begin
        if (cnt_q == 6'(rtpl_pkg::PROD_W - 1)) begin
          ph_d = PH_IDLE;
          ov_d = 1'b1;
        end
      end
      default: ph_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_IDLE;
      ov_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      ph_q <= ph_d;
      ov_q <= ov_d;
      if (ph_q == PH_DIV) cnt_q <= cnt_q + 1'b1;
      else                cnt_q <= '0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q  <= head_i;
      delta_q <= head_i.ts_delta;
      rate_q  <= head_i.rate;
      tns_q   <= '0;
    end
    if (ph_q == PH_MUL) begin
      dq_q  <= rtpl_pkg::PROD_W'(delta_q) * rtpl_pkg::PROD_W'(rtpl_pkg::NS_PER_S);
      rem_q <= '0;
    end else if (ph_q == PH_DIV) begin
      dq_q  <= {dq_q[rtpl_pkg::PROD_W-2:0], qbit};
      rem_q <= qbit ? 18'(trial - {1'b0, rate_q}) : trial[17:0];
      if (cnt_q == 6'(rtpl_pkg::PROD_W - 1)) begin
        tns_q <= {dq_q[50:0], qbit};
      end
    end
  end

endmodule

@@ design/rtp_l16_depacketizer.sv @@
// top level of the rtp l16 depacketizer
// a byte is registered in the queue and then in the output register
// throughput: one byte per cycle without stalls, but the last byte of a packet
// holds the back end for the 62-step restoring divider forming the time stamp
// a 4-entry queue lets the parser take header bytes while the divider runs
// reset: asynchronous active low, parser state and config return to defaults
module rtp_l16_depacketizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [17:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        payload_valid_o,
  output logic [7:0]  payload_byte_o,
  output logic        end_of_packet_o,
  output logic [1:0]  rtp_version_o,
  output logic        marker_bit_o,
  output logic [6:0]  packet_type_o,
  output logic [15:0] sequence_res_o,
  output logic [31:0] source_id_o,
  output logic [7:0]  trim_count_o,
  output logic [51:0] time_ns_o,
  output logic [1:0]  channel_count_o,
  output logic        unknown_type_o
);

  rtpl_pkg::item_t f_item, q_head, o_item;
  logic full, avail, pop, take;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign take        = in_valid_i && !full;

  rtpl_front u_front (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .in_take_i(take), .data_byte_i, .first_byte_i, .last_byte_i,
    .item_o(f_item)
  );

  rtpl_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(take), .push_item_i(f_item), .full_o(full),
    .pop_i(pop), .avail_o(avail), .head_o(q_head)
  );

  rtpl_back u_back (
    .clk_i, .rst_ni,
    .avail_i(avail), .head_i(q_head), .pop_o(pop),
    .out_valid_o, .out_stall_i, .out_item_o(o_item), .time_ns_o
  );

  // result fields
  assign payload_valid_o = o_item.payload_valid;
  assign payload_byte_o  = o_item.payload_byte;
  assign end_of_packet_o = o_item.end_of_packet;
  assign rtp_version_o   = o_item.rtp_version;
  assign marker_bit_o    = o_item.marker_bit;
  assign packet_type_o   = o_item.packet_type;
  assign sequence_res_o  = o_item.sequence_res;
  assign source_id_o     = o_item.source_id;
  assign trim_count_o    = o_item.trim_count;
  assign channel_count_o = o_item.channel_count;
  assign unknown_type_o  = o_item.unknown_type;

endmodule

@@ design/rtpl_checker.sv @@
// port level checks for the rtp l16 depacketizer
module rtpl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        payload_valid_o,
  input logic [7:0]  payload_byte_o,
  input logic        end_of_packet_o,
  input logic [7:0]  trim_count_o,
  input logic [51:0] time_ns_o,
  input logic [31:0] source_id_o,
  input logic [1:0]  channel_count_o
);

  // a stalled transaction holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(payload_byte_o) &&
    $stable(end_of_packet_o))
    else $error("stalled result changed");

  // non payload bytes read as zero
  a_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !payload_valid_o |-> payload_byte_o == 8'h00)
    else $error("non payload byte not zero");

  // header fields only on the packet end
  a_mid_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !end_of_packet_o |->
    trim_count_o == 8'h00 && time_ns_o == 52'd0 && source_id_o == 32'd0)
    else $error("header fields set mid packet");

  // channel count always 1 or 2
  a_channels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> channel_count_o == 2'd1 || channel_count_o == 2'd2)
    else $error("bad channel count");

endmodule

bind rtp_l16_depacketizer rtpl_checker u_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .payload_valid_o, .payload_byte_o,
  .end_of_packet_o, .trim_count_o, .time_ns_o, .source_id_o, .channel_count_o
);
